// File: design/lasc_pkg.sv
// lasc_pkg: shared types and constants of the local alignment score core
// no dependencies; imported by lasc_cell, local_alignment_score_core and tb
`timescale 1ns / 1ps

package lasc_pkg;

    localparam int MAX_LEN_DEF = 256;
    localparam int SYM_W       = 8;
    localparam int ACT_W       = 2;
    localparam int SCORE_W     = 9;

    localparam int MATCH_GAIN    = 1;
    localparam int MISMATCH_COST = 2;
    localparam int GAP_COST      = 2;

    localparam logic [ACT_W-1:0] ACT_REF = 2'd0;
    localparam logic [ACT_W-1:0] ACT_TGT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_END = 2'd2;

    typedef struct packed {
        logic             valid;
        logic [SYM_W-1:0] sym;
    } t_wave_tag;

    typedef struct packed {
        logic load;
        logic clear;
    } t_cell_ctl;

endpackage

// File: design/lasc_cell.sv
// lasc_cell: one reference column of the alignment chain
// holds the column symbol and score row entry; uses lasc_pkg
`timescale 1ns / 1ps

module lasc_cell
    import lasc_pkg::*;
#(
    parameter int SW = SCORE_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  logic [SYM_W-1:0] i_load_sym,
    input  t_wave_tag        i_tag,
    input  logic [SW-1:0]    i_left,
    input  logic [SW-1:0]    i_diag,
    input  logic [SW-1:0]    i_best,
    output t_wave_tag        o_tag,
    output logic [SW-1:0]    o_left,
    output logic [SW-1:0]    o_diag,
    output logic [SW-1:0]    o_best
);

    logic [SYM_W-1:0] r_sym;
    logic             r_used;
    logic [SW-1:0]    r_row;
    logic             r_tag_valid;
    logic [SYM_W-1:0] r_tag_sym;
    logic [SW-1:0]    r_left;
    logic [SW-1:0]    r_diag;
    logic [SW-1:0]    r_best;

    logic [SW-1:0] w_sub;
    logic [SW-1:0] w_gap_left;
    logic [SW-1:0] w_gap_up;
    logic [SW-1:0] w_cell;
    logic [SW-1:0] w_tmp;
    logic          w_active;

    always_comb begin
        if (r_sym == i_tag.sym) begin
            w_sub = i_diag + SW'(MATCH_GAIN);
        end else if (i_diag >= SW'(MISMATCH_COST)) begin
            w_sub = i_diag - SW'(MISMATCH_COST);
        end else begin
            w_sub = '0;
        end
        w_gap_left = (i_left >= SW'(GAP_COST)) ? i_left - SW'(GAP_COST) : '0;
        w_gap_up   = (r_row >= SW'(GAP_COST)) ? r_row - SW'(GAP_COST) : '0;
        w_tmp      = (w_gap_left > w_gap_up) ? w_gap_left : w_gap_up;
        w_cell     = (w_sub > w_tmp) ? w_sub : w_tmp;
        w_active   = i_tag.valid && r_used;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= 1'b0;
            r_row       <= '0;
            r_tag_valid <= 1'b0;
        end else begin
            r_tag_valid <= i_tag.valid;
            if (i_ctl.clear) begin
                r_used <= 1'b0;
                r_row  <= '0;
            end else if (i_ctl.load) begin
                r_used <= 1'b1;
                r_row  <= '0;
            end else if (w_active) begin
                r_row <= w_cell;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_sym <= i_load_sym;
        end
        r_tag_sym <= i_tag.sym;
        r_left    <= w_cell;
        r_diag    <= r_row;
        r_best    <= (w_active && (w_cell > i_best)) ? w_cell : i_best;
    end

    assign o_tag  = '{valid: r_tag_valid, sym: r_tag_sym};
    assign o_left = r_left;
    assign o_diag = r_diag;
    assign o_best = r_best;

endmodule

// File: design/local_alignment_score_core.sv
// local_alignment_score_core: top level, a chain of MAX_LEN alignment cells
// depends on lasc_pkg and lasc_cell
//
// channel   valid     stall     payload
// input     i_valid   o_stall   i_action, i_symbol
// output    o_valid   i_stall   o_score
//
// a target item is taken every cycle and runs down the chain one cell per cycle;
// from acceptance it passes the input register and every cell before its row
// maximum reaches the best score register. a reference or end item waits until
// the chain holds no target item; an end item also waits for the result
// register to be free. reset clears every cell at once, no clearing pass
`timescale 1ns / 1ps

module local_alignment_score_core
    import lasc_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [ACT_W-1:0]   i_action,
    input  logic [SYM_W-1:0]   i_symbol,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [SCORE_W-1:0] o_score
);

    localparam int SW = $clog2(MAX_LEN + 1);
    localparam int CW = $clog2(MAX_LEN + 2);

    logic [SW-1:0] r_ref_len;
    logic [SW-1:0] r_tgt_len;
    logic [SW-1:0] r_best;
    logic [CW-1:0] r_inflight;
    logic          r_in_valid;
    logic [SYM_W-1:0] r_in_sym;
    logic          r_out_valid;
    logic [SCORE_W-1:0] r_out_score;

    logic [SW-1:0] n_best;
    logic [CW-1:0] n_inflight;
    logic [SW-1:0] w_result;

    logic w_accept;
    logic w_busy;
    logic w_ref_fire;
    logic w_tgt_fire;
    logic w_end_fire;
    logic w_exit;

    t_wave_tag     w_tag  [MAX_LEN+1];
    logic [SW-1:0] w_left [MAX_LEN+1];
    logic [SW-1:0] w_diag [MAX_LEN+1];
    logic [SW-1:0] w_bst  [MAX_LEN+1];

    always_comb begin
        w_busy = (r_inflight != '0);
        o_stall = 1'b0;
        if (i_valid) begin
            case (i_action)
                ACT_REF: o_stall = w_busy;
                ACT_END: o_stall = w_busy || (r_out_valid && i_stall);
                default: o_stall = 1'b0;
            endcase
        end
        w_accept   = i_valid && !o_stall;
        w_ref_fire = w_accept && (i_action == ACT_REF);
        w_tgt_fire = w_accept && (i_action == ACT_TGT);
        w_end_fire = w_accept && (i_action == ACT_END);
        w_exit     = w_tag[MAX_LEN].valid;

        n_inflight = r_inflight + CW'(w_tgt_fire) - CW'(w_exit);
        n_best = (w_exit && (w_bst[MAX_LEN] > r_best)) ? w_bst[MAX_LEN] : r_best;

        if (r_ref_len == '0) begin
            w_result = r_tgt_len;
        end else if (r_tgt_len == '0) begin
            w_result = r_ref_len;
        end else begin
            w_result = r_best;
        end
    end

    assign w_tag[0]  = '{valid: r_in_valid, sym: r_in_sym};
    assign w_left[0] = '0;
    assign w_diag[0] = '0;
    assign w_bst[0]  = '0;

    for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
        t_cell_ctl w_ctl;
        assign w_ctl = '{load: w_ref_fire && (r_ref_len == SW'(j)), clear: w_end_fire};

        lasc_cell #(
            .SW (SW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_load_sym (i_symbol),
            .i_tag      (w_tag[j]),
            .i_left     (w_left[j]),
            .i_diag     (w_diag[j]),
            .i_best     (w_bst[j]),
            .o_tag      (w_tag[j+1]),
            .o_left     (w_left[j+1]),
            .o_diag     (w_diag[j+1]),
            .o_best     (w_bst[j+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_len   <= '0;
            r_tgt_len   <= '0;
            r_best      <= '0;
            r_inflight  <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid <= w_tgt_fire;
            r_inflight <= n_inflight;
            if (w_end_fire) begin
                r_ref_len   <= '0;
                r_tgt_len   <= '0;
                r_best      <= '0;
                r_out_valid <= 1'b1;
            end else begin
                r_best <= n_best;
                if (r_out_valid && !i_stall) begin
                    r_out_valid <= 1'b0;
                end
                if (w_ref_fire && (r_ref_len != SW'(MAX_LEN))) begin
                    r_ref_len <= r_ref_len + SW'(1);
                end
                if (w_tgt_fire && (r_tgt_len != SW'(MAX_LEN))) begin
                    r_tgt_len <= r_tgt_len + SW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_sym <= i_symbol;
        if (w_end_fire) begin
            r_out_score <= SCORE_W'(w_result);
        end
    end

    assign o_valid = r_out_valid;
    assign o_score = r_out_score;

    // reference symbols only enter an empty chain
    a_ref_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ref_fire |-> (r_inflight == '0))
        else $error("reference item taken while targets in flight");

    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= CW'(MAX_LEN + 1))
        else $error("in-flight count out of range");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end_fire |=> (r_ref_len == '0) && (r_tgt_len == '0) && o_valid)
        else $error("end item did not clear pair state");

    a_ref_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ref_len <= SW'(MAX_LEN))
        else $error("reference length beyond limit");

endmodule

// File: test/tb.sv
// tb: self-checking bench for local_alignment_score_core, scoring random sequence pairs
// against an in-bench local alignment row model, with random idling on both channels
// depends on lasc_pkg and the design sources
`timescale 1ns / 1ps

module tb;
    import lasc_pkg::*;

    localparam int MAX_LEN = MAX_LEN_DEF;
    localparam int N_ITEMS = 1850;
    localparam int LIMIT = 2000000;
    localparam int HOLD_CYCLES = 800;
    localparam int HOLD_AFTER = 900;
    localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic [SYM_W-1:0] sym;
    } t_seq_item;

    logic               i_clk;
    logic               i_rst_n  = 1'b0;
    logic               i_valid  = 1'b0;
    logic [ACT_W-1:0]   i_action = '0;
    logic [SYM_W-1:0]   i_symbol = '0;
    logic               i_stall  = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [SCORE_W-1:0] o_score;

    t_seq_item          feed_q[$];
    logic [SCORE_W-1:0] score_q[$];
    t_seq_item          drv_item;
    int                 n_gen;
    int                 n_acc     = 0;
    int                 n_err     = 0;
    int                 cycle     = 0;
    int                 hold_left = 0;
    logic               held      = 1'b0;
    logic               calm;

    // alignment state
    logic [SYM_W-1:0]   ref_sym[MAX_LEN];
    int                 row_cell[MAX_LEN];
    int                 ref_cnt;
    int                 tgt_cnt;
    int                 best;

    local_alignment_score_core #(.MAX_LEN(MAX_LEN)) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_action (i_action),
        .i_symbol (i_symbol),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_score  (o_score)
    );

    assign calm = (n_acc >= 300) && (n_acc < 700);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void clear_pair();
        ref_cnt = 0;
        tgt_cnt = 0;
        best    = 0;
        for (int j = 0; j < MAX_LEN; j++) row_cell[j] = 0;
    endfunction

    function automatic void put_score(input logic [SCORE_W-1:0] v);
        score_q.insert(score_q.size(), v);
    endfunction

    function automatic void align_step(input logic [ACT_W-1:0] act, input logic [SYM_W-1:0] sym);
        int left;
        int diag;
        int up;
        int val;
        case (act)
            ACT_REF: begin
                if (ref_cnt < MAX_LEN) begin
                    ref_sym[ref_cnt]  = sym;
                    row_cell[ref_cnt] = 0;
                    ref_cnt++;
                end
            end
            ACT_TGT: begin
                left = 0;
                diag = 0;
                for (int j = 0; j < ref_cnt; j++) begin
                    up  = row_cell[j];
                    val = (ref_sym[j] == sym) ? diag + MATCH_GAIN : diag - MISMATCH_COST;
                    if (left - GAP_COST > val) val = left - GAP_COST;
                    if (up - GAP_COST > val) val = up - GAP_COST;
                    if (val < 0) val = 0;
                    if (val > best) best = val;
                    diag        = up;
                    row_cell[j] = val;
                    left        = val;
                end
                if (tgt_cnt < MAX_LEN) tgt_cnt++;
            end
            ACT_END: begin
                if (ref_cnt == 0) put_score(tgt_cnt[SCORE_W-1:0]);
                else if (tgt_cnt == 0) put_score(ref_cnt[SCORE_W-1:0]);
                else put_score(best[SCORE_W-1:0]);
                clear_pair();
            end
            default: ;
        endcase
    endfunction

    function automatic void push_item(input logic [ACT_W-1:0] act, input logic [SYM_W-1:0] sym);
        t_seq_item it;
        it.act = act;
        it.sym = sym;
        feed_q.insert(feed_q.size(), it);
        n_gen++;
    endfunction

    // well-formed pair over a small alphabet, target loosely copied from the reference
    function automatic void add_pair();
        logic [SYM_W-1:0] alpha[4];
        logic [SYM_W-1:0] rs[16];
        logic [SYM_W-1:0] s;
        int nref;
        int ntgt;
        int off;
        for (int k = 0; k < 4; k++) alpha[k] = SYM_W'($urandom);
        nref = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 15);
        ntgt = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 15);
        off  = $urandom_range(0, 4);
        for (int k = 0; k < nref; k++) begin
            rs[k] = ($urandom_range(0, 9) == 0) ? SYM_W'($urandom)
                                                : alpha[$urandom_range(0, 3)];
            push_item(ACT_REF, rs[k]);
        end
        for (int k = 0; k < ntgt; k++) begin
            s = alpha[$urandom_range(0, 3)];
            if (k + off < nref && $urandom_range(0, 3) != 0) s = rs[k + off];
            if ($urandom_range(0, 19) == 0) s = SYM_W'($urandom);
            push_item(ACT_TGT, s);
        end
        if ($urandom_range(0, 7) == 0) begin
            push_item(ACT_REF, alpha[$urandom_range(0, 3)]);
            if ($urandom_range(0, 1) == 0) push_item(ACT_TGT, alpha[$urandom_range(0, 3)]);
        end
        if ($urandom_range(0, 9) == 0) push_item(ACT_NOP, SYM_W'($urandom));
        push_item(ACT_END, SYM_W'($urandom));
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) begin
                align_step(i_action, i_symbol);
                n_acc <= n_acc + 1;
            end
            if (feed_q.size() != 0 && (calm || $urandom_range(0, 99) >= 25)) begin
                drv_item = feed_q.pop_front();
                i_valid  <= 1'b1;
                i_action <= drv_item.act;
                i_symbol <= drv_item.sym;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with one long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && !held && n_acc >= HOLD_AFTER) begin
            held      <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= !calm && ($urandom_range(0, 99) < 25);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (score_q.size() == 0) begin
                if (n_err < 10) $display("unexpected result: score %0d", o_score);
                n_err <= n_err + 1;
            end else begin
                if (o_score !== score_q[0]) begin
                    if (n_err < 10)
                        $display("score mismatch: expected %0d, got %0d", score_q[0], o_score);
                    n_err <= n_err + 1;
                end
                void'(score_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) cycle <= cycle + 1;

    initial begin
        while (cycle < LIMIT) @(posedge i_clk);
        $display("** local_alignment_score_core: FAILED **");
        $finish;
    end

    initial begin
        logic [SYM_W-1:0] s;
        logic             big_done;
        n_gen    = 0;
        big_done = 1'b0;
        clear_pair();

        // both sequences empty, then target only, then reference only
        push_item(ACT_END, 8'h00);
        push_item(ACT_TGT, 8'h00);
        push_item(ACT_TGT, 8'hFF);
        push_item(ACT_END, 8'hFF);
        push_item(ACT_REF, 8'hFF);
        push_item(ACT_REF, 8'h00);
        push_item(ACT_REF, 8'hA5);
        push_item(ACT_END, 8'h5A);
        // matching run, unused action, late append
        push_item(ACT_REF, 8'h41);
        push_item(ACT_REF, 8'h43);
        push_item(ACT_REF, 8'h47);
        push_item(ACT_NOP, 8'hFF);
        push_item(ACT_TGT, 8'h41);
        push_item(ACT_TGT, 8'h43);
        push_item(ACT_TGT, 8'h47);
        push_item(ACT_REF, 8'h54);
        push_item(ACT_TGT, 8'h54);
        push_item(ACT_END, 8'h00);
        // lone mismatch
        push_item(ACT_REF, 8'h5A);
        push_item(ACT_TGT, 8'hA5);
        push_item(ACT_END, 8'hA5);

        while (n_gen < N_ITEMS) begin
            if (!big_done && n_gen >= 1000) begin
                // full reference, saturated target count, top score
                big_done = 1'b1;
                s = SYM_W'($urandom);
                for (int k = 0; k < MAX_LEN + 2; k++) push_item(ACT_REF, s);
                for (int k = 0; k < MAX_LEN + 2; k++) push_item(ACT_TGT, s);
                push_item(ACT_END, s);
            end else if ($urandom_range(0, 99) < 85) begin
                add_pair();
            end else begin
                for (int k = $urandom_range(1, 8); k > 0; k--)
                    push_item(ACT_W'($urandom_range(0, 3)), SYM_W'($urandom));
                push_item(ACT_END, SYM_W'($urandom));
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (feed_q.size() != 0 || i_valid || score_q.size() != 0) @(posedge i_clk);
        repeat (2 * MAX_LEN + 16) @(posedge i_clk);
        if (n_err == 0 && score_q.size() == 0) begin
            $display("** local_alignment_score_core: PASSED **");
        end else begin
            $display("** local_alignment_score_core: FAILED **");
        end
        $finish;
    end

endmodule
